[rtl/core/tlik_pkg.sv]
// Shared widths, constants and sideband types of the leg inverse kinematics pipeline.
package tlik_pkg;

  localparam int POS_W  = 16;
  localparam int LEN_W  = 15;
  localparam int SQ_L_W = 30;
  localparam int R2_W   = 32;
  localparam int RQ_W   = 24;
  localparam int NUM_W  = 51;
  localparam int DEN_W  = 41;
  localparam int DN_W   = 31;
  localparam int DIF_W  = 2 * DN_W;
  localparam int N3_W   = 34;
  localparam int CIN_W  = 33;
  localparam int CX_W   = 44;
  localparam int ACC_W  = 26;
  localparam int SUM_W  = 28;
  localparam int CORDIC_LIM_BITS = 38;
  localparam int CORDIC_STEPS = 22;
  localparam int OUT_SHIFT = 10;
  localparam int NUM_SHIFT = 16;

  localparam int LATENCY = 3 + RQ_W + 1 + 2 + DN_W + 1 + CORDIC_STEPS + 1;

  localparam logic signed [ACC_W-1:0] DEG90  = 26'sd5898240;
  localparam logic signed [ACC_W-1:0] DEG180 = 26'sd11796480;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = 28'sd512;

  localparam int ATAN_TAB [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2
  };

  localparam logic REG_UPPER = 1'b0;
  localparam logic REG_LOWER = 1'b1;
  localparam logic [LEN_W-1:0] LEN_RESET = 15'd1280;

  typedef struct packed {
    logic                    unreach;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] z;
    logic [LEN_W-1:0]        l1;
    logic [LEN_W-1:0]        l2;
    logic signed [N3_W-1:0]  nh;
    logic signed [N3_W-1:0]  na;
    logic signed [N3_W-1:0]  nk;
    logic [R2_W-1:0]         dk;
  } side48_t;

  typedef struct packed {
    logic                    unreach;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] z;
  } tilt_side_t;

  typedef struct packed {
    tilt_side_t      t;
    logic            negh;
    logic [DN_W-1:0] mh;
    logic            nega;
    logic [DN_W-1:0] ma;
    logic            negk;
    logic [DN_W-1:0] mk;
  } side62_t;

endpackage

[rtl/core/tlik_sqrt_cell.sv]
// One digit cell of the pipelined integer square root.
module tlik_sqrt_cell #(
  parameter int RW = 24
) (
  input  logic            clk,
  input  logic [2*RW-1:0] rad_in,
  input  logic [RW+1:0]   rem_in,
  input  logic [RW-1:0]   root_in,
  output logic [2*RW-1:0] rad_out,
  output logic [RW+1:0]   rem_out,
  output logic [RW-1:0]   root_out
);

  logic [RW+3:0] cur;
  logic [RW+3:0] trial;
  logic [RW+3:0] diff;
  logic          take;

  always_comb begin
    cur   = {rem_in, rad_in[2*RW-1 -: 2]};
    trial = {2'b00, root_in, 2'b01};
    take  = cur >= trial;
    diff  = cur - trial;
  end

  always_ff @(posedge clk) begin
    rad_out <= {rad_in[2*RW-3:0], 2'b00};
    if (take) begin
      rem_out  <= diff[RW+1:0];
      root_out <= {root_in[RW-2:0], 1'b1};
    end else begin
      rem_out  <= cur[RW+1:0];
      root_out <= {root_in[RW-2:0], 1'b0};
    end
  end

endmodule

[rtl/core/tlik_acos_front.sv]
// Operand scaling for acos: normalize the ratio, clamp, and form den^2 - num^2.
module tlik_acos_front (
  input  logic                               clk,
  input  logic signed [tlik_pkg::NUM_W-1:0]  num,
  input  logic [tlik_pkg::DEN_W-1:0]         den,
  output logic                               neg,
  output logic [tlik_pkg::DN_W-1:0]          m,
  output logic [tlik_pkg::DIF_W-1:0]         diff
);

  localparam int NW = tlik_pkg::NUM_W;
  localparam int DW = tlik_pkg::DEN_W;
  localparam int NDW = tlik_pkg::DN_W;
  localparam int SW = tlik_pkg::DIF_W;

  logic [NW-1:0]  mag;
  logic [5:0]     dlen;
  logic [5:0]     sh;
  logic [DW-1:0]  ds;
  logic [NW-1:0]  ms;
  logic [NDW-1:0] mn;
  logic           neg_a;
  logic [NDW-1:0] d_a;
  logic [NDW-1:0] m_a;
  logic [SW-1:0]  dsq;
  logic [SW-1:0]  msq;

  always_comb begin
    mag  = NW'(num[NW-1] ? -num : num);
    dlen = '0;
    for (int i = 0; i < DW; i++) begin
      if (den[i]) dlen = 6'(i + 1);
    end
    sh = (dlen > 6'(NDW)) ? dlen - 6'(NDW) : 6'd0;
    ds = den >> sh;
    ms = mag >> sh;
    if (ms > NW'(ds)) mn = ds[NDW-1:0];
    else mn = ms[NDW-1:0];
  end

  always_ff @(posedge clk) begin
    neg_a <= num[NW-1];
    d_a   <= ds[NDW-1:0];
    m_a   <= mn;
  end

  always_comb begin
    dsq = SW'(d_a) * SW'(d_a);
    msq = SW'(m_a) * SW'(m_a);
  end

  always_ff @(posedge clk) begin
    neg  <= neg_a;
    m    <= m_a;
    diff <= dsq - msq;
  end

endmodule

[rtl/core/tlik_cordic_norm.sv]
// CORDIC entry: scale the vector up to the working range and fold the left half plane.
module tlik_cordic_norm (
  input  logic                              clk,
  input  logic signed [tlik_pkg::CIN_W-1:0] x_in,
  input  logic signed [tlik_pkg::CIN_W-1:0] y_in,
  output logic signed [tlik_pkg::CX_W-1:0]  x_out,
  output logic signed [tlik_pkg::CX_W-1:0]  y_out,
  output logic signed [tlik_pkg::ACC_W-1:0] acc_out
);

  localparam int IW = tlik_pkg::CIN_W;
  localparam int XW = tlik_pkg::CX_W;

  logic [IW-1:0]          ax;
  logic [IW-1:0]          ay;
  logic [IW-1:0]          mm;
  logic [5:0]             blen;
  logic [5:0]             sh;
  logic signed [XW-1:0]   xe;
  logic signed [XW-1:0]   ye;

  always_comb begin
    ax = IW'(x_in[IW-1] ? -x_in : x_in);
    ay = IW'(y_in[IW-1] ? -y_in : y_in);
    mm = ax | ay;
    blen = '0;
    for (int i = 0; i < IW; i++) begin
      if (mm[i]) blen = 6'(i + 1);
    end
    sh = 6'(tlik_pkg::CORDIC_LIM_BITS + 1) - blen;
    xe = XW'(x_in) <<< sh;
    ye = XW'(y_in) <<< sh;
  end

  always_ff @(posedge clk) begin
    if (xe < 0) begin
      x_out   <= ye;
      y_out   <= -xe;
      acc_out <= tlik_pkg::DEG90;
    end else begin
      x_out   <= xe;
      y_out   <= ye;
      acc_out <= '0;
    end
  end

endmodule

[rtl/core/tlik_cordic_cell.sv]
// One vectoring iteration of the pipelined CORDIC.
module tlik_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                              clk,
  input  logic signed [tlik_pkg::CX_W-1:0]  x_in,
  input  logic signed [tlik_pkg::CX_W-1:0]  y_in,
  input  logic signed [tlik_pkg::ACC_W-1:0] acc_in,
  output logic signed [tlik_pkg::CX_W-1:0]  x_out,
  output logic signed [tlik_pkg::CX_W-1:0]  y_out,
  output logic signed [tlik_pkg::ACC_W-1:0] acc_out
);

  localparam logic signed [tlik_pkg::ACC_W-1:0] ANG =
    tlik_pkg::ACC_W'(tlik_pkg::ATAN_TAB[STEP]);

  logic signed [tlik_pkg::CX_W-1:0] xs;
  logic signed [tlik_pkg::CX_W-1:0] ys;

  always_comb begin
    xs = x_in >>> STEP;
    ys = y_in >>> STEP;
  end

  always_ff @(posedge clk) begin
    if (y_in > 0) begin
      x_out   <= x_in + ys;
      y_out   <= y_in - xs;
      acc_out <= acc_in + ANG;
    end else begin
      x_out   <= x_in - ys;
      y_out   <= y_in + xs;
      acc_out <= acc_in - ANG;
    end
  end

endmodule

[rtl/core/two_link_leg_inverse_kinematics.sv]
// Top level: two-link leg inverse kinematics, fully pipelined fixed-point datapath.
//
//  channel   handshake               payload
//  --------  ----------------------  ------------------------------------------------
//  target    start & !busy           target_x, target_z
//  result    strobe (one cycle)      hip_angle, knee_angle, ankle_angle, unreachable
//  config    APB psel/penable/pwrite upper_segment_length @0, lower_segment_length @4
//
//  The pipeline has 3 setup stages, 24 cells of the reach square root,
//  3 scaling stages, 31 cells of the acos square roots, CORDIC entry and 22
//  CORDIC cells, and the output register. One item enters every cycle; busy
//  stays low. Reset clears the valid line and sets the segment lengths to 1280.
//  The receiver cannot stall: each result shows for exactly one cycle.
module two_link_leg_inverse_kinematics (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  target_x,
  input  logic signed [15:0]  target_z,
  output logic                strobe,
  output logic signed [15:0]  hip_angle,
  output logic [13:0]         knee_angle,
  output logic signed [14:0]  ankle_angle,
  output logic                unreachable,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int LAT   = tlik_pkg::LATENCY;
  localparam int POS_W = tlik_pkg::POS_W;
  localparam int LEN_W = tlik_pkg::LEN_W;
  localparam int LW    = tlik_pkg::SQ_L_W;
  localparam int R2_W  = tlik_pkg::R2_W;
  localparam int RQ_W  = tlik_pkg::RQ_W;
  localparam int NW    = tlik_pkg::NUM_W;
  localparam int DW    = tlik_pkg::DEN_W;
  localparam int NDW   = tlik_pkg::DN_W;
  localparam int SW    = tlik_pkg::DIF_W;
  localparam int N3W   = tlik_pkg::N3_W;
  localparam int IW    = tlik_pkg::CIN_W;
  localparam int XW    = tlik_pkg::CX_W;
  localparam int AW    = tlik_pkg::ACC_W;
  localparam int UW    = tlik_pkg::SUM_W;
  localparam int NC    = tlik_pkg::CORDIC_STEPS;

  // configuration
  logic [LEN_W-1:0] upper_len;
  logic [LEN_W-1:0] lower_len;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_len <= tlik_pkg::LEN_RESET;
      lower_len <= tlik_pkg::LEN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        tlik_pkg::REG_UPPER: upper_len <= pwdata[LEN_W-1:0];
        tlik_pkg::REG_LOWER: lower_len <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tlik_pkg::REG_UPPER: prdata = {{(32-LEN_W){1'b0}}, upper_len};
      tlik_pkg::REG_LOWER: prdata = {{(32-LEN_W){1'b0}}, lower_len};
      default:             prdata = '0;
    endcase
  end

  // item valid line
  logic [LAT-1:0] vpipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], start & ~busy};
    end
  end

  assign strobe = vpipe[LAT-1];

  // stage 0: capture
  logic signed [POS_W-1:0] x0, z0;
  logic [LEN_W-1:0]        l1_0, l2_0;

  always_ff @(posedge clk) begin
    x0   <= target_x;
    z0   <= target_z;
    l1_0 <= upper_len;
    l2_0 <= lower_len;
  end

  // stage 1: squares and products
  logic signed [31:0]      sq_x, sq_z;
  logic [R2_W-1:0]         r2_1;
  logic [LW-1:0]           l1sq_1, l2sq_1, l1l2_1;
  logic                    bad_1;
  logic signed [POS_W-1:0] x1, z1;
  logic [LEN_W-1:0]        l1_1, l2_1;

  always_comb begin
    sq_x = 32'(x0) * 32'(x0);
    sq_z = 32'(z0) * 32'(z0);
  end

  always_ff @(posedge clk) begin
    r2_1   <= $unsigned(sq_x) + $unsigned(sq_z);
    l1sq_1 <= LW'(l1_0) * LW'(l1_0);
    l2sq_1 <= LW'(l2_0) * LW'(l2_0);
    l1l2_1 <= LW'(l1_0) * LW'(l2_0);
    bad_1  <= (z0 <= 16'sd0) || (l1_0 == '0) || (l2_0 == '0);
    x1     <= x0;
    z1     <= z0;
    l1_1   <= l1_0;
    l2_1   <= l2_0;
  end

  // stage 2: reach tests and law-of-cosines numerators
  logic [R2_W:0]             sum2;
  logic [R2_W-1:0]           diff2;
  tlik_pkg::side48_t         s2_side;
  logic [2*RQ_W-1:0]         rad_2;

  always_comb begin
    sum2  = (R2_W+1)'(l1sq_1) + (R2_W+1)'(l2sq_1) + (R2_W+1)'({l1l2_1, 1'b0});
    diff2 = R2_W'(l1sq_1) + R2_W'(l2sq_1) - R2_W'({l1l2_1, 1'b0});
  end

  always_ff @(posedge clk) begin
    s2_side.unreach <= bad_1 || ((R2_W+1)'(r2_1) > sum2) || (r2_1 < diff2);
    s2_side.x       <= x1;
    s2_side.z       <= z1;
    s2_side.l1      <= l1_1;
    s2_side.l2      <= l2_1;
    s2_side.nh      <= N3W'(l1sq_1) + N3W'(r2_1) - N3W'(l2sq_1);
    s2_side.na      <= N3W'(l2sq_1) + N3W'(r2_1) - N3W'(l1sq_1);
    s2_side.nk      <= N3W'(l1sq_1) + N3W'(l2sq_1) - N3W'(r2_1);
    s2_side.dk      <= R2_W'({l1l2_1, 1'b0});
    rad_2           <= {r2_1, 16'h0000};
  end

  // reach square root, one result bit per cell
  logic [2*RQ_W-1:0] rad48  [RQ_W+1];
  logic [RQ_W+1:0]   rem48  [RQ_W+1];
  logic [RQ_W-1:0]   root48 [RQ_W+1];
  tlik_pkg::side48_t side48 [RQ_W];

  assign rad48[0]  = rad_2;
  assign rem48[0]  = '0;
  assign root48[0] = '0;

  for (genvar i = 0; i < RQ_W; i++) begin : g_sq48
    tlik_sqrt_cell #(.RW(RQ_W)) u_cell (
      .clk      (clk),
      .rad_in   (rad48[i]),
      .rem_in   (rem48[i]),
      .root_in  (root48[i]),
      .rad_out  (rad48[i+1]),
      .rem_out  (rem48[i+1]),
      .root_out (root48[i+1])
    );
  end

  always_ff @(posedge clk) begin
    side48[0] <= s2_side;
    for (int i = 1; i < RQ_W; i++) side48[i] <= side48[i-1];
  end

  // stage 3: acos operands
  tlik_pkg::side48_t          sd;
  logic [RQ_W-1:0]            rq;
  logic [DW-2:0]              ph, pa;
  logic signed [NW-1:0]       num_h, num_a, num_k;
  logic [DW-1:0]              den_h, den_a, den_k;
  tlik_pkg::tilt_side_t       s3_t;

  assign sd = side48[RQ_W-1];
  assign rq = root48[RQ_W];

  always_comb begin
    ph = (DW-1)'(sd.l1) * (DW-1)'(rq);
    pa = (DW-1)'(sd.l2) * (DW-1)'(rq);
  end

  always_ff @(posedge clk) begin
    num_h        <= NW'(sd.nh) <<< tlik_pkg::NUM_SHIFT;
    num_a        <= NW'(sd.na) <<< tlik_pkg::NUM_SHIFT;
    num_k        <= NW'(sd.nk);
    den_h        <= {ph, 1'b0};
    den_a        <= {pa, 1'b0};
    den_k        <= DW'(sd.dk);
    s3_t.unreach <= sd.unreach;
    s3_t.x       <= sd.x;
    s3_t.z       <= sd.z;
  end

  // acos scaling, two stages each
  logic            fh_neg, fa_neg, fk_neg;
  logic [NDW-1:0]  fh_m, fa_m, fk_m;
  logic [SW-1:0]   fh_d, fa_d, fk_d;
  tlik_pkg::tilt_side_t sf1, sf2;

  tlik_acos_front u_front_h (
    .clk (clk), .num (num_h), .den (den_h), .neg (fh_neg), .m (fh_m), .diff (fh_d)
  );
  tlik_acos_front u_front_a (
    .clk (clk), .num (num_a), .den (den_a), .neg (fa_neg), .m (fa_m), .diff (fa_d)
  );
  tlik_acos_front u_front_k (
    .clk (clk), .num (num_k), .den (den_k), .neg (fk_neg), .m (fk_m), .diff (fk_d)
  );

  always_ff @(posedge clk) begin
    sf1 <= s3_t;
    sf2 <= sf1;
  end

  // acos square roots
  logic [SW-1:0]    radh [NDW+1], rada [NDW+1], radk [NDW+1];
  logic [NDW+1:0]   remh [NDW+1], rema [NDW+1], remk [NDW+1];
  logic [NDW-1:0]   rooth [NDW+1], roota [NDW+1], rootk [NDW+1];
  tlik_pkg::side62_t side62 [NDW];

  assign radh[0] = fh_d;
  assign rada[0] = fa_d;
  assign radk[0] = fk_d;
  assign remh[0] = '0;
  assign rema[0] = '0;
  assign remk[0] = '0;
  assign rooth[0] = '0;
  assign roota[0] = '0;
  assign rootk[0] = '0;

  for (genvar i = 0; i < NDW; i++) begin : g_sq62
    tlik_sqrt_cell #(.RW(NDW)) u_cell_h (
      .clk (clk), .rad_in (radh[i]), .rem_in (remh[i]), .root_in (rooth[i]),
      .rad_out (radh[i+1]), .rem_out (remh[i+1]), .root_out (rooth[i+1])
    );
    tlik_sqrt_cell #(.RW(NDW)) u_cell_a (
      .clk (clk), .rad_in (rada[i]), .rem_in (rema[i]), .root_in (roota[i]),
      .rad_out (rada[i+1]), .rem_out (rema[i+1]), .root_out (roota[i+1])
    );
    tlik_sqrt_cell #(.RW(NDW)) u_cell_k (
      .clk (clk), .rad_in (radk[i]), .rem_in (remk[i]), .root_in (rootk[i]),
      .rad_out (radk[i+1]), .rem_out (remk[i+1]), .root_out (rootk[i+1])
    );
  end

  always_ff @(posedge clk) begin
    side62[0].t    <= sf2;
    side62[0].negh <= fh_neg;
    side62[0].mh   <= fh_m;
    side62[0].nega <= fa_neg;
    side62[0].ma   <= fa_m;
    side62[0].negk <= fk_neg;
    side62[0].mk   <= fk_m;
    for (int i = 1; i < NDW; i++) side62[i] <= side62[i-1];
  end

  // CORDIC entry
  tlik_pkg::side62_t    se;
  logic signed [IW-1:0] mh_s, ma_s, mk_s;
  logic signed [IW-1:0] cx_h, cx_a, cx_k;

  assign se = side62[NDW-1];

  always_comb begin
    mh_s = $signed({2'b00, se.mh});
    ma_s = $signed({2'b00, se.ma});
    mk_s = $signed({2'b00, se.mk});
    cx_h = se.negh ? -mh_s : mh_s;
    cx_a = se.nega ? -ma_s : ma_s;
    cx_k = se.negk ? -mk_s : mk_s;
  end

  logic signed [XW-1:0] cxt [NC+1], cyt [NC+1];
  logic signed [XW-1:0] cxh [NC+1], cyh [NC+1];
  logic signed [XW-1:0] cxa [NC+1], cya [NC+1];
  logic signed [XW-1:0] cxk [NC+1], cyk [NC+1];
  logic signed [AW-1:0] act [NC+1], ach [NC+1], aca [NC+1], ack [NC+1];
  logic [NC:0]          uline;

  tlik_cordic_norm u_norm_t (
    .clk (clk), .x_in (IW'(se.t.z)), .y_in (IW'(se.t.x)),
    .x_out (cxt[0]), .y_out (cyt[0]), .acc_out (act[0])
  );
  tlik_cordic_norm u_norm_h (
    .clk (clk), .x_in (cx_h), .y_in ($signed({2'b00, rooth[NDW]})),
    .x_out (cxh[0]), .y_out (cyh[0]), .acc_out (ach[0])
  );
  tlik_cordic_norm u_norm_a (
    .clk (clk), .x_in (cx_a), .y_in ($signed({2'b00, roota[NDW]})),
    .x_out (cxa[0]), .y_out (cya[0]), .acc_out (aca[0])
  );
  tlik_cordic_norm u_norm_k (
    .clk (clk), .x_in (cx_k), .y_in ($signed({2'b00, rootk[NDW]})),
    .x_out (cxk[0]), .y_out (cyk[0]), .acc_out (ack[0])
  );

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    tlik_cordic_cell #(.STEP(i)) u_cell_t (
      .clk (clk), .x_in (cxt[i]), .y_in (cyt[i]), .acc_in (act[i]),
      .x_out (cxt[i+1]), .y_out (cyt[i+1]), .acc_out (act[i+1])
    );
    tlik_cordic_cell #(.STEP(i)) u_cell_h (
      .clk (clk), .x_in (cxh[i]), .y_in (cyh[i]), .acc_in (ach[i]),
      .x_out (cxh[i+1]), .y_out (cyh[i+1]), .acc_out (ach[i+1])
    );
    tlik_cordic_cell #(.STEP(i)) u_cell_a (
      .clk (clk), .x_in (cxa[i]), .y_in (cya[i]), .acc_in (aca[i]),
      .x_out (cxa[i+1]), .y_out (cya[i+1]), .acc_out (aca[i+1])
    );
    tlik_cordic_cell #(.STEP(i)) u_cell_k (
      .clk (clk), .x_in (cxk[i]), .y_in (cyk[i]), .acc_in (ack[i]),
      .x_out (cxk[i+1]), .y_out (cyk[i+1]), .acc_out (ack[i+1])
    );
  end

  always_ff @(posedge clk) begin
    uline <= {uline[NC-1:0], se.t.unreach};
  end

  // output: combine, round, saturate
  logic signed [UW-1:0] hip_s, knee_s, ank_s;
  logic signed [UW-1:0] hip_v, knee_v, ank_v;
  logic signed [15:0]   hip_c;
  logic [13:0]          knee_c;
  logic signed [14:0]   ank_c;

  always_comb begin
    hip_s  = UW'(act[NC]) + UW'(ach[NC]) + tlik_pkg::ROUND_HALF;
    knee_s = UW'(tlik_pkg::DEG180) - UW'(ack[NC]) + tlik_pkg::ROUND_HALF;
    ank_s  = UW'(tlik_pkg::DEG90) + UW'(act[NC]) - UW'(aca[NC]) + tlik_pkg::ROUND_HALF;
    hip_v  = hip_s >>> tlik_pkg::OUT_SHIFT;
    knee_v = knee_s >>> tlik_pkg::OUT_SHIFT;
    ank_v  = ank_s >>> tlik_pkg::OUT_SHIFT;

    if (hip_v < -28'sd32768) hip_c = -16'sd32768;
    else if (hip_v > 28'sd32767) hip_c = 16'sd32767;
    else hip_c = hip_v[15:0];

    if (knee_v < 28'sd0) knee_c = '0;
    else if (knee_v > 28'sd16383) knee_c = 14'd16383;
    else knee_c = knee_v[13:0];

    if (ank_v < -28'sd16384) ank_c = -15'sd16384;
    else if (ank_v > 28'sd16383) ank_c = 15'sd16383;
    else ank_c = ank_v[14:0];
  end

  always_ff @(posedge clk) begin
    if (uline[NC]) begin
      hip_angle   <= '0;
      knee_angle  <= '0;
      ankle_angle <= '0;
      unreachable <= 1'b1;
    end else begin
      hip_angle   <= hip_c;
      knee_angle  <= knee_c;
      ankle_angle <= ank_c;
      unreachable <= 1'b0;
    end
  end

endmodule

[rtl/core/tlik_checker.sv]
// Port-level checks of the leg inverse kinematics block, bound to the top level.
module tlik_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic signed [15:0]  target_z,
  input logic                strobe,
  input logic signed [15:0]  hip_angle,
  input logic [13:0]         knee_angle,
  input logic signed [14:0]  ankle_angle,
  input logic                unreachable
);

  localparam int LAT = tlik_pkg::LATENCY;

  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && unreachable |-> hip_angle == 16'sd0 && knee_angle == 14'd0 &&
                              ankle_angle == 15'sd0)
    else $error("unreachable item with nonzero angles");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !strobe)
    else $error("item after reset");

  a_low_target: assert property (@(posedge clk) disable iff (rst)
    start && !busy && target_z[15] |-> ##LAT strobe && unreachable)
    else $error("target below hip not flagged");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy, LAT))
    else $error("result without an accepted item");

endmodule

bind two_link_leg_inverse_kinematics tlik_checker u_tlik_checker (.*);
